[hw/rtl/mfmsd_pkg.sv]
// Shared types, constants and helpers for the MFM sector decoder.
// No dependencies; used by every module of the block but the FIFO.
package mfmsd_pkg;

  // Data bits of an MFM longword
  localparam logic [31:0] DATA_BIT_MASK = 32'h5555_5555;

  // Defaults for the top-level parameters
  localparam int DATA_WORDS_DEF   = 128;
  localparam int CMD_DEPTH_DEF    = 4;
  localparam int RESULT_DEPTH_DEF = 4;

  // Fixed word positions of the sector layout
  localparam int POS_INFO_ODD     = 0;
  localparam int POS_INFO_EVEN    = 1;
  localparam int POS_LABEL_LAST   = 9;
  localparam int POS_HDR_SUM_ODD  = 10;
  localparam int POS_HDR_SUM_EVEN = 11;
  localparam int POS_DAT_SUM_ODD  = 12;
  localparam int POS_DAT_SUM_EVEN = 13;
  localparam int POS_DATA_ODD     = 14;

  // Work codes handed from front to back
  typedef enum logic [2:0] {
    OP_INFO_ODD,
    OP_INFO_EVEN,
    OP_HDR_XOR,
    OP_HOLD_ODD,
    OP_HDR_CHECK,
    OP_DSUM_EVEN,
    OP_DATA_ODD,
    OP_DATA_EVEN
  } op_t;

  // One command in the front-to-back queue
  typedef struct packed {
    op_t         op;
    logic [31:0] raw;
    logic        last;
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic        kind;
    logic [31:0] word_value;
    logic        header_ok;
    logic        data_ok;
    logic        last;
  } res_t;

  // Merge odd and even halves into a decoded longword
  function automatic logic [31:0] mfm_join(input logic [31:0] odd, input logic [31:0] even);
    mfm_join = ((odd & DATA_BIT_MASK) << 1) | (even & DATA_BIT_MASK);
  endfunction

endpackage

[hw/rtl/mfmsd_fifo.sv]
// Small synchronous FIFO used for the command queue and the result queue.
// Standalone; DEPTH must be a power of two.
module mfmsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hw/rtl/mfmsd_front.sv]
// Front end: tracks the word position in the sector and classifies each beat.
// Depends on mfmsd_pkg.
module mfmsd_front #(
  parameter int DATA_WORDS = mfmsd_pkg::DATA_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [31:0]      raw_word,
  input  logic             sector_start,
  input  logic             header_only,
  output logic             cmd_push,
  output mfmsd_pkg::cmd_t  cmd
);

  localparam int POS_DATA_EVEN = mfmsd_pkg::POS_DATA_ODD + DATA_WORDS;
  localparam int POS_END       = POS_DATA_EVEN + DATA_WORDS;
  localparam int POS_W         = $clog2(POS_END + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] eff_pos, pos_inc;
  logic             active;

  // Classify the beat by its position
  always_comb begin
    eff_pos  = sector_start ? '0 : pos_r;
    pos_inc  = eff_pos + 1'b1;
    active   = (eff_pos < POS_W'(POS_END));
    cmd.raw  = raw_word;
    cmd.last = 1'b0;
    if (eff_pos == POS_W'(mfmsd_pkg::POS_INFO_ODD)) begin
      cmd.op = mfmsd_pkg::OP_INFO_ODD;
    end else if (eff_pos == POS_W'(mfmsd_pkg::POS_INFO_EVEN)) begin
      cmd.op = mfmsd_pkg::OP_INFO_EVEN;
    end else if (eff_pos <= POS_W'(mfmsd_pkg::POS_LABEL_LAST)) begin
      cmd.op = mfmsd_pkg::OP_HDR_XOR;
    end else if (eff_pos == POS_W'(mfmsd_pkg::POS_HDR_SUM_ODD) ||
                 eff_pos == POS_W'(mfmsd_pkg::POS_DAT_SUM_ODD)) begin
      cmd.op = mfmsd_pkg::OP_HOLD_ODD;
    end else if (eff_pos == POS_W'(mfmsd_pkg::POS_HDR_SUM_EVEN)) begin
      cmd.op   = mfmsd_pkg::OP_HDR_CHECK;
      cmd.last = header_only;
    end else if (eff_pos == POS_W'(mfmsd_pkg::POS_DAT_SUM_EVEN)) begin
      cmd.op = mfmsd_pkg::OP_DSUM_EVEN;
    end else if (eff_pos < POS_W'(POS_DATA_EVEN)) begin
      cmd.op = mfmsd_pkg::OP_DATA_ODD;
    end else begin
      cmd.op   = mfmsd_pkg::OP_DATA_EVEN;
      cmd.last = (pos_inc == POS_W'(POS_END));
    end
  end

  assign cmd_push = accept && active;

  // Advance the position; header-only mode ends the sector at the header result
  always_comb begin
    pos_nxt = pos_r;
    if (accept && active) begin
      if (cmd.op == mfmsd_pkg::OP_HDR_CHECK && header_only) begin
        pos_nxt = POS_W'(POS_END);
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_W'(POS_END);
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

[hw/rtl/mfmsd_back.sv]
// Back end: checksums, odd-half buffer and result assembly, two stages deep.
// Depends on mfmsd_pkg.
module mfmsd_back #(
  parameter int DATA_WORDS = mfmsd_pkg::DATA_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  mfmsd_pkg::cmd_t  cmd,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output mfmsd_pkg::res_t  res
);

  localparam int IDX_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  logic [31:0]      odd_half_mem [DATA_WORDS];
  logic [31:0]      rd_data_r;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  logic [31:0] odd_hold_r, odd_hold_nxt;
  logic [31:0] info_r, info_nxt;
  logic [31:0] hdr_sum_r, hdr_sum_nxt;
  logic [31:0] sdat_sum_r, sdat_sum_nxt;
  logic [31:0] dat_sum_r, dat_sum_nxt;
  logic        hdr_match_r, hdr_match_nxt;

  logic        s2_valid_r, s2_valid_nxt;
  logic        s2_kind_r;
  logic [31:0] s2_word_r;
  logic        s2_hok_r;
  logic        s2_dok_r;
  logic        s2_last_r;

  logic        adv, fire, emit;
  logic        hdr_cmp;
  logic [31:0] dat_sum_upd;

  // Stage 2 drains into the result queue; stage 1 moves when stage 2 frees
  assign adv      = !s2_valid_r || !res_full;
  assign fire     = cmd_valid && adv;
  assign cmd_pop  = fire;
  assign emit     = (cmd.op == mfmsd_pkg::OP_HDR_CHECK) ||
                    (cmd.op == mfmsd_pkg::OP_DATA_EVEN);
  assign hdr_cmp  = ((hdr_sum_r & mfmsd_pkg::DATA_BIT_MASK) ==
                     mfmsd_pkg::mfm_join(odd_hold_r, cmd.raw));
  assign dat_sum_upd = dat_sum_r ^ cmd.raw;

  // Stage 1: update sums and buffer indexes
  always_comb begin
    odd_hold_nxt  = odd_hold_r;
    info_nxt      = info_r;
    hdr_sum_nxt   = hdr_sum_r;
    sdat_sum_nxt  = sdat_sum_r;
    dat_sum_nxt   = dat_sum_r;
    hdr_match_nxt = hdr_match_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    if (fire) begin
      case (cmd.op)
        mfmsd_pkg::OP_INFO_ODD: begin
          odd_hold_nxt = cmd.raw;
          hdr_sum_nxt  = cmd.raw;
        end
        mfmsd_pkg::OP_INFO_EVEN: begin
          info_nxt    = mfmsd_pkg::mfm_join(odd_hold_r, cmd.raw);
          hdr_sum_nxt = hdr_sum_r ^ cmd.raw;
        end
        mfmsd_pkg::OP_HDR_XOR: begin
          hdr_sum_nxt = hdr_sum_r ^ cmd.raw;
        end
        mfmsd_pkg::OP_HOLD_ODD: begin
          odd_hold_nxt = cmd.raw;
        end
        mfmsd_pkg::OP_HDR_CHECK: begin
          hdr_match_nxt = hdr_cmp;
        end
        mfmsd_pkg::OP_DSUM_EVEN: begin
          sdat_sum_nxt = mfmsd_pkg::mfm_join(odd_hold_r, cmd.raw);
          dat_sum_nxt  = '0;
          wr_idx_nxt   = '0;
          rd_idx_nxt   = '0;
        end
        mfmsd_pkg::OP_DATA_ODD: begin
          dat_sum_nxt = dat_sum_upd;
          wr_idx_nxt  = wr_idx_r + 1'b1;
        end
        mfmsd_pkg::OP_DATA_EVEN: begin
          dat_sum_nxt = dat_sum_upd;
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end
        default: begin
          odd_hold_nxt = odd_hold_r;
        end
      endcase
    end
  end

  // Hold stage 2 until the result queue takes it
  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (adv) begin
      s2_valid_nxt = fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_hold_r  <= '0;
      info_r      <= '0;
      hdr_sum_r   <= '0;
      sdat_sum_r  <= '0;
      dat_sum_r   <= '0;
      hdr_match_r <= 1'b0;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      s2_valid_r  <= 1'b0;
    end else begin
      odd_hold_r  <= odd_hold_nxt;
      info_r      <= info_nxt;
      hdr_sum_r   <= hdr_sum_nxt;
      sdat_sum_r  <= sdat_sum_nxt;
      dat_sum_r   <= dat_sum_nxt;
      hdr_match_r <= hdr_match_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      s2_valid_r  <= s2_valid_nxt;
    end
  end

  // Stage 2 payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind_r <= (cmd.op == mfmsd_pkg::OP_DATA_EVEN);
      s2_word_r <= (cmd.op == mfmsd_pkg::OP_DATA_EVEN) ? cmd.raw : info_r;
      s2_hok_r  <= (cmd.op == mfmsd_pkg::OP_HDR_CHECK) ? hdr_cmp : hdr_match_r;
      s2_dok_r  <= (cmd.op == mfmsd_pkg::OP_DATA_EVEN) && cmd.last &&
                   ((dat_sum_upd & mfmsd_pkg::DATA_BIT_MASK) == sdat_sum_r);
      s2_last_r <= cmd.last;
    end
  end

  // Odd-half buffer: write odd halves, read ahead for the even half
  always_ff @(posedge clk) begin
    if (fire && cmd.op == mfmsd_pkg::OP_DATA_ODD) begin
      odd_half_mem[wr_idx_r] <= cmd.raw;
    end
    if (adv) begin
      rd_data_r <= odd_half_mem[rd_idx_r];
    end
  end

  // Assemble the result beat
  assign res_push       = s2_valid_r && !res_full;
  assign res.kind       = s2_kind_r;
  assign res.word_value = s2_kind_r ? mfmsd_pkg::mfm_join(rd_data_r, s2_word_r) : s2_word_r;
  assign res.header_ok  = s2_hok_r;
  assign res.data_ok    = s2_dok_r;
  assign res.last       = s2_last_r;

endmodule

[hw/rtl/mfm_sector_decoder_unit.sv]
// MFM sector decoder top level: front end, command queue, back end, result queue.
// A result beat passes the command queue, back-end stage 2 and the result queue.
// Throughput: one input beat per cycle while full is low, set by the back-end stage
// and the odd-half buffer's one write and one read port.
// Reset (rst_n low, synchronous): queues empty, position idle, sums cleared,
// header_only cleared; the odd-half buffer is not cleared.
module mfm_sector_decoder_unit #(
  parameter int DATA_WORDS   = mfmsd_pkg::DATA_WORDS_DEF,
  parameter int CMD_DEPTH    = mfmsd_pkg::CMD_DEPTH_DEF,
  parameter int RESULT_DEPTH = mfmsd_pkg::RESULT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_raw_word,
  input  logic        in_sector_start,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [31:0] out_word_value,
  output logic        out_header_ok,
  output logic        out_data_ok,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_header_only
);

  logic             header_only_r, header_only_nxt;
  logic             accept;
  logic             cmd_push, cmd_pop, cmd_full, cmd_empty;
  mfmsd_pkg::cmd_t  cmd_in, cmd_out;
  logic             res_push, res_full;
  mfmsd_pkg::res_t  res_in, res_out;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_comb begin
    header_only_nxt = header_only_r;
    if (cfg_valid && cfg_ready) begin
      header_only_nxt = cfg_header_only;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_only_r <= 1'b0;
    end else begin
      header_only_r <= header_only_nxt;
    end
  end

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  mfmsd_front #(
    .DATA_WORDS (DATA_WORDS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .raw_word     (in_raw_word),
    .sector_start (in_sector_start),
    .header_only  (header_only_r),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  mfmsd_fifo #(
    .WIDTH ($bits(mfmsd_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  mfmsd_back #(
    .DATA_WORDS (DATA_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  mfmsd_fifo #(
    .WIDTH ($bits(mfmsd_pkg::res_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_kind       = res_out.kind;
  assign out_word_value = res_out.word_value;
  assign out_header_ok  = res_out.header_ok;
  assign out_data_ok    = res_out.data_ok;
  assign out_last       = res_out.last;

  // Header beats never carry a data checksum flag
  a_hdr_no_dok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_kind) |-> !out_data_ok)
    else $error("header beat carries data_ok");

  // Data checksum flag only on the final beat of a sector
  a_dok_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data_ok) |-> out_last)
    else $error("data_ok on a beat that is not last");

  // No result waits right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result queue not empty after reset");

endmodule
